// ===== rtl/core/decimal_digit_splitter_with_dots_unit_macros.svh =====
// Assertion macros for the decimal digit splitter checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef DECIMAL_DIGIT_SPLITTER_WITH_DOTS_UNIT_MACROS_SVH
`define DECIMAL_DIGIT_SPLITTER_WITH_DOTS_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted, fixed message.
`define DDSU_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ddsu check failed");

// Same, with a caller-supplied message string.
`define DDSU_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/core/ddsu_pkg.sv =====
// Shared constants and helpers for the decimal digit splitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ddsu_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned POS_W          = 4;
  localparam int unsigned MAX_DIGITS_DEF = 8;
  // 10^10 - 1 fits in 34 bits, enough for the widest setting
  localparam int unsigned LIMIT_W        = 34;

  localparam logic [POS_W-1:0] DOT_POS_A = POS_W'(4);
  localparam logic [POS_W-1:0] DOT_POS_B = POS_W'(7);

  // Largest value that fits on the display: 10^n - 1
  function automatic logic [LIMIT_W-1:0] display_limit(input int unsigned n);
    logic [LIMIT_W-1:0] lim;
    lim = LIMIT_W'(1);
    for (int unsigned i = 0; i < n; i++) begin
      lim = LIMIT_W'(lim * LIMIT_W'(10));
    end
    return LIMIT_W'(lim - LIMIT_W'(1));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ddsu_dabble.sv =====
// Bit-serial binary to BCD converter (shift-and-add-3), one input bit per cycle.
// Depends on ddsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddsu_dabble #(
  parameter int unsigned MAX_DIGITS = ddsu_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [ddsu_pkg::VALUE_W-1:0]        in_value_i,
  output logic                                     bcd_valid_o,
  input  wire logic                                bcd_ready_i,
  output logic [4*MAX_DIGITS-1:0]                  bcd_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;
  localparam int unsigned VW    = ddsu_pkg::VALUE_W;
  localparam int unsigned LW    = ddsu_pkg::LIMIT_W;
  localparam int unsigned CNT_W = $clog2(VW);
  localparam logic [LW-1:0]    LIMIT    = ddsu_pkg::display_limit(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [VW-1:0]      bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BCD_W-1:0]   corr;
  logic               in_range;

  assign in_range = (LW'(in_value_i) <= LIMIT);

  // add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    logic [3:0] nib;
    nib  = '0;
    corr = '0;
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      nib = bcd_q[4*i +: 4];
      corr[4*i +: 4] = (nib >= 4'd5) ? 4'(nib + 4'd3) : nib;
    end
  end

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_range) begin
          // out-of-range values are taken and dropped
          state_d = ST_SHIFT;
          bin_d   = in_value_i;
          bcd_d   = '0;
          cnt_d   = '0;
        end
      end
      ST_SHIFT: begin
        bcd_d = {corr[BCD_W-2:0], bin_q[VW-1]};
        bin_d = {bin_q[VW-2:0], 1'b0};
        cnt_d = CNT_W'(cnt_q + CNT_W'(1));
        if (cnt_q == CNT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (bcd_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign bcd_valid_o = (state_q == ST_DONE);
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

// ===== rtl/core/ddsu_emit.sv =====
// Digit emitter: shifts the BCD word out one digit per transfer, units first.
// Depends on ddsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddsu_emit #(
  parameter int unsigned MAX_DIGITS = ddsu_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          bcd_valid_i,
  output logic                               bcd_ready_o,
  input  wire logic [4*MAX_DIGITS-1:0]       bcd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ddsu_pkg::DIGIT_W-1:0]       digit_o,
  output logic [ddsu_pkg::POS_W-1:0]         position_o,
  output logic                               dot_o,
  output logic                               last_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;
  localparam int unsigned PW    = ddsu_pkg::POS_W;

  logic [BCD_W-1:0] rest_q;
  logic [PW-1:0]    pos_q;
  logic             valid_q;
  logic             load;
  logic             advance;

  assign bcd_ready_o = !valid_q;
  assign load        = bcd_valid_i && !valid_q;
  assign advance     = valid_q && out_ready_i;

  // run ends when no nonzero digit is left above the current one
  assign last_o = ((rest_q >> 4) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance && last_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rest_q <= bcd_i;
      pos_q  <= PW'(1);
    end else if (advance) begin
      rest_q <= rest_q >> 4;
      pos_q  <= PW'(pos_q + PW'(1));
    end
  end

  assign out_valid_o = valid_q;
  assign digit_o     = rest_q[3:0];
  assign position_o  = pos_q;
  assign dot_o       = (pos_q == ddsu_pkg::DOT_POS_A) || (pos_q == ddsu_pkg::DOT_POS_B);

endmodule

`default_nettype wire

// ===== rtl/core/decimal_digit_splitter_with_dots_unit.sv =====
// The first digit is offered once the value has passed the 32-step bit-serial BCD converter
// and been loaded into the digit emitter; then one digit per cycle while the sink is ready.
// The converter takes no new value until the emitter has taken its BCD word; conversion of
// the next value overlaps digit output. An out-of-range value does not enter the converter.
// Out-of-range values are accepted and give no transfer. Reset (rst_ni, async low)
// clears all handshake state; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_splitter_with_dots_unit #(
  parameter int unsigned MAX_DIGITS = ddsu_pkg::MAX_DIGITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [3:0] digit, [7:4] position, [8] dot, zero above
  output logic             m_axis_tlast
);

  logic                              bcd_valid;
  logic                              bcd_ready;
  logic [4*MAX_DIGITS-1:0]           bcd;
  logic [ddsu_pkg::DIGIT_W-1:0]      digit;
  logic [ddsu_pkg::POS_W-1:0]        position;
  logic                              dot;

  ddsu_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .bcd_valid_o (bcd_valid),
    .bcd_ready_i (bcd_ready),
    .bcd_o       (bcd)
  );

  ddsu_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bcd_valid_i (bcd_valid),
    .bcd_ready_o (bcd_ready),
    .bcd_i       (bcd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .digit_o     (digit),
    .position_o  (position),
    .dot_o       (dot),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, dot, position, digit};

endmodule

`default_nettype wire

// ===== rtl/core/ddsu_checker.sv =====
// Port-level checks for the decimal digit splitter, bound to the top level.
// Depends on decimal_digit_splitter_with_dots_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "decimal_digit_splitter_with_dots_unit_macros.svh"

module ddsu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  `DDSU_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `DDSU_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `DDSU_ASSERT_MSG(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "digit run broken before tlast")
  `DDSU_ASSERT_MSG(a_dot_pos, m_axis_tvalid |-> (m_axis_tdata[8] == ((m_axis_tdata[7:4] == 4'd4) || (m_axis_tdata[7:4] == 4'd7))), "dot flag disagrees with position")
  `DDSU_ASSERT_MSG(a_digit_dec, m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9), "digit is not decimal")

endmodule

bind decimal_digit_splitter_with_dots_unit ddsu_checker u_ddsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/tb_decimal_digit_splitter_with_dots_unit.sv =====
// Testbench for decimal_digit_splitter_with_dots_unit: streams values in, checks every
// digit transfer against an in-bench digit predictor with random stalls on both sides.
// Depends on ddsu_pkg and the unit RTL only.
`timescale 1ns / 1ps

module tb_decimal_digit_splitter_with_dots_unit;

  localparam int unsigned NUM_DIGITS  = ddsu_pkg::MAX_DIGITS_DEF;
  localparam int unsigned RAND_VALUES = 180;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN       = 80;   // > one full conversion + 8 digits

  localparam logic [31:0] CORNERS [20] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd9999, 32'd10000, 32'd999999, 32'd1000000, 32'd9999999, 32'd10000000,
    32'd99999999, 32'd100000000, 32'hFFFF_FFFF, 32'h8000_0000,
    32'd12345678, 32'd90807060
  };

  typedef struct packed {
    logic [ddsu_pkg::DIGIT_W-1:0] digit;
    logic [ddsu_pkg::POS_W-1:0]   position;
    logic                         dot;
    logic                         last;
  } digit_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [3:0] digit, [7:4] position, [8] dot
  logic        m_axis_tlast;

  logic [31:0] values_pending [$];
  digit_t      digits_due [$];
  int unsigned n_sent    = 0;
  int unsigned err_cnt   = 0;
  logic        sink_hold = 1'b0;

  decimal_digit_splitter_with_dots_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue the digits a value should produce, units first; nothing if it overflows.
  function automatic void predict_digits(input logic [31:0] value);
    longint unsigned top;
    logic [31:0]     rest;
    int unsigned     ndig;
    int unsigned     pos;
    digit_t          d;
    top = 1;
    for (pos = 0; pos < NUM_DIGITS; pos++) top = top * 10;
    if (longint'(value) > top - 1) return;
    ndig = 1;
    rest = value;
    while (rest >= 10) begin
      rest = rest / 10;
      ndig++;
    end
    rest = value;
    for (pos = 1; pos <= ndig; pos++) begin
      d.digit    = ddsu_pkg::DIGIT_W'(rest % 10);
      d.position = ddsu_pkg::POS_W'(pos);
      d.dot      = (d.position == ddsu_pkg::DOT_POS_A) || (d.position == ddsu_pkg::DOT_POS_B);
      d.last     = (pos == ndig);
      digits_due.push_back(d);
      rest = rest / 10;
    end
  endfunction

  // No random idles on either side while n_sent is from 60 to 109.
  function automatic int unsigned idle_pct();
    return (n_sent >= 60 && n_sent < 110) ? 0 : 20;
  endfunction

  function automatic void note_error(input string what, input int unsigned want,
                                     input int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  // Source: one NBA per signal per edge; predict on the accepting edge.
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) begin
        predict_digits(s_axis_tdata);
        n_sent <= n_sent + 1;
      end
      if (values_pending.size() != 0 && $urandom_range(99) >= idle_pct()) begin
        s_axis_tdata  <= values_pending.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink ready, with a long hold-off to back the unit up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni || sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct());
    end
  end

  initial begin : hold_off
    wait (n_sent >= 140);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : watch
    digit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digits_due.size() == 0) begin
        note_error("unexpected transfer, tdata", 0, m_axis_tdata);
      end else begin
        want = digits_due.pop_front();
        if (m_axis_tdata[3:0] != want.digit)
          note_error("digit", want.digit, m_axis_tdata[3:0]);
        if (m_axis_tdata[7:4] != want.position)
          note_error("position", want.position, m_axis_tdata[7:4]);
        if (m_axis_tdata[8] != want.dot)
          note_error("dot", want.dot, m_axis_tdata[8]);
        if (m_axis_tlast != want.last)
          note_error("tlast", want.last, m_axis_tlast);
        if (m_axis_tdata[15:9] != '0)
          note_error("tdata padding", 0, m_axis_tdata[15:9]);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] v;
    int unsigned k;
    int unsigned j;
    int unsigned nd;
    int unsigned span;
    foreach (CORNERS[i]) values_pending.push_back(CORNERS[i]);
    for (k = 0; k < RAND_VALUES; k++) begin
      j = $urandom_range(99);
      if (j < 8) begin
        v = $urandom;
      end else if (j < 12) begin
        v = 32'd100000000 + $urandom_range(1000);
      end else begin
        // pick a digit count first so short and long numbers both show up
        nd   = $urandom_range(NUM_DIGITS, 1);
        span = 1;
        for (j = 1; j < nd; j++) span = span * 10;
        v = $urandom_range(span * 10 - 1, (nd == 1) ? 0 : span);
      end
      values_pending.push_back(v);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (values_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_decimal_digit_splitter_with_dots_unit passed");
    end else begin
      $display("tb_decimal_digit_splitter_with_dots_unit failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_500_000;
    $display("tb_decimal_digit_splitter_with_dots_unit failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ddsu_pkg.sv
rtl/core/ddsu_dabble.sv
rtl/core/ddsu_emit.sv
rtl/core/decimal_digit_splitter_with_dots_unit.sv
rtl/core/ddsu_checker.sv
verif/tb_decimal_digit_splitter_with_dots_unit.sv
